/* rtl/rvwap_pkg.sv */
// ----------------------------------------------------------------------------
// rvwap_pkg
// Shared widths, field offsets, register map and control types for the
// rolling VWAP core.
// ----------------------------------------------------------------------------
`default_nettype none

package rvwap_pkg;

	// Window storage and fixed-point format
	localparam int MAX_WINDOW    = 256;
	localparam int FRACTION_BITS = 16;

	// Field widths
	localparam int PRICE_W = 24;
	localparam int VOL_W   = 28;
	localparam int TMS_W   = 48;
	localparam int TIME_W  = 39;
	localparam int VWAP_W  = 40;
	localparam int WIN_W   = 9;

	// Datapath widths
	localparam int SUM3_W = PRICE_W + 2;
	localparam int TERM_W = SUM3_W + VOL_W;
	localparam int WSUM_W = 62;
	localparam int VSUM_W = 36;
	localparam int DEN_W  = VSUM_W + 2;
	localparam int NUM_W  = WSUM_W + FRACTION_BITS;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int FILL_W = $clog2(MAX_WINDOW + 1);

	// Millisecond to second conversion
	localparam int MS_PER_S = 1000;

	// Seconds by reciprocal multiplication: the millisecond value is taken in
	// 16-bit slices, low slice first, each multiplied by ceil(2^53 / 1000) and
	// added to the running product shifted right by one slice. The quotient
	// is exact for every 48-bit time.
	localparam int TCHUNK_W   = 16;
	localparam int TIME_STEPS = TMS_W / TCHUNK_W;
	localparam int TIME_SHIFT = 53;
	localparam int TACC_W     = 60;
	localparam int TIME_LSB   = TIME_SHIFT - TCHUNK_W * (TIME_STEPS - 1);
	localparam logic [TACC_W-1:0] TIME_RECIP = 60'd9007199254741;

	// Stream packing
	localparam int HI_LSB      = 0;
	localparam int LO_LSB      = HI_LSB + PRICE_W;
	localparam int CL_LSB      = LO_LSB + PRICE_W;
	localparam int VOL_LSB     = CL_LSB + PRICE_W;
	localparam int TMS_LSB     = VOL_LSB + VOL_W;
	localparam int IN_TDATA_W  = ((TMS_LSB + TMS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((TIME_W + VWAP_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - TIME_W - VWAP_W;

	// Register map
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam logic [APB_AW-1:0] ADDR_WINDOW = 3'd0;
	localparam logic [WIN_W-1:0]  WIN_RESET   = 9'd20;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUB,
		S_ADD,
		S_INIT,
		S_DIV,
		S_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic sub;
		logic add;
		logic init;
		logic step;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/rolling_vwap_core.sv */
// ----------------------------------------------------------------------------
// rolling_vwap_core
// Rolling volume-weighted average price over a window of candles.
// ----------------------------------------------------------------------------
// One candle is taken at a time. A candle that only fills the window passes
// through the multiply, retire and add states before the next transfer.
// A candle that yields a result then also passes through the init, divide and
// output states: the VWAP comes from a restoring long divider that produces
// one quotient bit per cycle over the 78-bit scaled numerator, and the seconds
// value comes from a reciprocal multiplication over three 16-bit slices of the
// time during the first divider steps. The result waits in an output register,
// so the next candle is taken while it is still pending. Writing the window
// register restarts the fill; the rings need no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_vwap_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Candle stream
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// [23:0] high_price, [47:24] low_price, [71:48] close_price,
	// [99:72] volume, [147:100] open_time_ms, [151:148] zero
	input  wire logic [rvwap_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Result stream
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [38:0] time_s, [78:39] vwap_value, [79] zero
	output logic      [rvwap_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [0] zero_volume
	output logic                                       m_axis_tuser,
	// Configuration port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [rvwap_pkg::APB_AW-1:0]          paddr,
	input  wire logic [rvwap_pkg::APB_DW-1:0]          pwdata,
	output logic      [rvwap_pkg::APB_DW-1:0]          prdata,
	output logic                                       pready
);

	import rvwap_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic             cfg_wr;
	logic [WIN_W-1:0] window;

	// Decode register writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW);
	assign prdata = (paddr == ADDR_WINDOW) ? APB_DW'(window) : '0;

	rvwap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rvwap_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.cfg_wr    (cfg_wr),
		.cfg_wdata (pwdata[WIN_W-1:0]),
		.window    (window),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* rtl/rvwap_ram.sv */
// ----------------------------------------------------------------------------
// rvwap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvwap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/rvwap_ctrl.sv */
// ----------------------------------------------------------------------------
// rvwap_ctrl
// Sequencer for one candle: capture, multiply, retire oldest entry, add new
// entry; if the window is full, run the serial divider and load the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rvwap_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rvwap_pkg::sts_t sts,
	output rvwap_pkg::cmd_t      cmd
);

	import rvwap_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_MUL;
			end
			S_MUL:  state_nxt = S_SUB;
			S_SUB:  state_nxt = S_ADD;
			S_ADD: begin
				state_nxt = sts.emit ? S_INIT : S_IDLE;
			end
			S_INIT: state_nxt = S_DIV;
			S_DIV: begin
				if (sts.div_last) state_nxt = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_MUL:  cmd.mul  = 1'b1;
			S_SUB:  cmd.sub  = 1'b1;
			S_ADD:  cmd.add  = 1'b1;
			S_INIT: cmd.init = 1'b1;
			S_DIV:  cmd.step = 1'b1;
			S_OUT:  cmd.out_load = sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/rvwap_dp.sv */
// ----------------------------------------------------------------------------
// rvwap_dp
// Datapath: window register, candle rings and running sums, bit-serial VWAP
// long division, sliced reciprocal multiply for the seconds value, output
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rvwap_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire rvwap_pkg::cmd_t                        cmd,
	output rvwap_pkg::sts_t                             sts,
	input  wire logic [rvwap_pkg::IN_TDATA_W-1:0]       in_data,
	input  wire logic                                   cfg_wr,
	input  wire logic [rvwap_pkg::WIN_W-1:0]            cfg_wdata,
	output logic      [rvwap_pkg::WIN_W-1:0]            window,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic      [rvwap_pkg::OUT_TDATA_W-1:0]      out_data,
	output logic                                        out_flag
);

	import rvwap_pkg::*;

	// Control and window state
	logic [WIN_W-1:0]  window_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [VSUM_W-1:0] vsum_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_valid_q;

	// Candle payload
	logic [SUM3_W-1:0] sum3_q;
	logic [VOL_W-1:0]  vol_q;
	logic [TMS_W-1:0]  tsh_q;
	logic [TERM_W-1:0] term_q;

	// Divider state
	logic [NUM_W-1:0]  nsh_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [VWAP_W-1:0] quo_q;
	logic              sat_q;
	logic              zero_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TACC_W-1:0] tacc_q;

	// Output stage
	logic [TIME_W-1:0] out_time_q;
	logic [VWAP_W-1:0] out_vwap_q;
	logic              out_zero_q;

	// Ring read data
	logic [TERM_W-1:0] old_term;
	logic [VOL_W-1:0]  old_vol;

	// Window bookkeeping
	logic [FILL_W-1:0] win_eff;
	logic              full;
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] slot_inc;
	logic [FILL_W-1:0] fill_nxt;
	logic [SLOT_W-1:0] slot_nxt;

	// Divider step
	logic [DEN_W:0]    rem_sh;
	logic              q_bit;
	logic [DEN_W-1:0]  rem_nxt;
	logic [VWAP_W:0]   quo_sh;
	logic [TACC_W-1:0] tacc_nxt;
	logic              time_step;

	// Clamp the window register to the usable range
	always_comb begin
		if (window_q == '0) begin
			win_eff = FILL_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			win_eff = FILL_W'(MAX_WINDOW);
		end else begin
			win_eff = FILL_W'(window_q);
		end
	end

	// Fill count and write slot advance
	always_comb begin
		full     = (fill_q >= win_eff);
		fill_inc = fill_q + FILL_W'(1);
		slot_inc = FILL_W'(slot_q) + FILL_W'(1);
		fill_nxt = full ? win_eff : fill_inc;
		slot_nxt = (slot_inc >= win_eff) ? '0 : SLOT_W'(slot_inc);
	end

	// Rings of per-candle terms and volumes
	rvwap_ram #(
		.WIDTH (TERM_W),
		.DEPTH (MAX_WINDOW)
	) u_term_ram (
		.clk   (clk),
		.we    (cmd.add),
		.waddr (slot_q),
		.wdata (term_q),
		.re    (cmd.mul),
		.raddr (slot_q),
		.rdata (old_term)
	);

	rvwap_ram #(
		.WIDTH (VOL_W),
		.DEPTH (MAX_WINDOW)
	) u_vol_ram (
		.clk   (clk),
		.we    (cmd.add),
		.waddr (slot_q),
		.wdata (vol_q),
		.re    (cmd.mul),
		.raddr (slot_q),
		.rdata (old_vol)
	);

	// Restoring division step for the VWAP, one time slice per early step
	always_comb begin
		rem_sh    = {rem_q, nsh_q[NUM_W-1]};
		q_bit     = (rem_sh >= {1'b0, den_q});
		rem_nxt   = q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
		quo_sh    = {quo_q, q_bit};
		tacc_nxt  = (tacc_q >> TCHUNK_W) + TACC_W'(tsh_q[TCHUNK_W-1:0]) * TIME_RECIP;
		time_step = (cnt_q >= CNT_W'(NUM_W - TIME_STEPS));
	end

	// Window register, running sums, fill count, slot, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			wsum_q      <= '0;
			vsum_q      <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_q <= cfg_wdata;
				wsum_q   <= '0;
				vsum_q   <= '0;
				fill_q   <= '0;
				slot_q   <= '0;
			end else begin
				// retire the oldest candle once the window is full
				if (cmd.sub && full) begin
					wsum_q <= wsum_q - WSUM_W'(old_term);
					vsum_q <= vsum_q - VSUM_W'(old_vol);
				end
				// add the new candle and advance the ring
				if (cmd.add) begin
					wsum_q <= wsum_q + WSUM_W'(term_q);
					vsum_q <= vsum_q + VSUM_W'(vol_q);
					fill_q <= fill_nxt;
					slot_q <= slot_nxt;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload, divider and output registers
	always_ff @(posedge clk) begin
		// capture the candle on transfer
		if (cmd.load) begin
			sum3_q <= SUM3_W'(in_data[HI_LSB +: PRICE_W]) + SUM3_W'(in_data[LO_LSB +: PRICE_W])
				+ SUM3_W'(in_data[CL_LSB +: PRICE_W]);
			vol_q  <= in_data[VOL_LSB +: VOL_W];
			tsh_q  <= in_data[TMS_LSB +: TMS_W];
		end
		if (cmd.mul) begin
			term_q <= TERM_W'(sum3_q) * TERM_W'(vol_q);
		end
		// load the divider and clear the seconds product
		if (cmd.init) begin
			nsh_q  <= NUM_W'(wsum_q) << FRACTION_BITS;
			den_q  <= DEN_W'(vsum_q) + DEN_W'({vsum_q, 1'b0});
			zero_q <= (vsum_q == '0);
			rem_q  <= '0;
			quo_q  <= '0;
			sat_q  <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
			tacc_q <= '0;
		end
		// one quotient bit per cycle; time slices go in over the first steps
		if (cmd.step) begin
			nsh_q <= nsh_q << 1;
			rem_q <= rem_nxt;
			quo_q <= quo_sh[VWAP_W-1:0];
			sat_q <= sat_q | quo_sh[VWAP_W];
			cnt_q <= cnt_q - CNT_W'(1);
			if (time_step) begin
				tsh_q  <= tsh_q >> TCHUNK_W;
				tacc_q <= tacc_nxt;
			end
		end
		// hold the result until the transfer completes
		if (cmd.out_load) begin
			out_time_q <= tacc_q[TIME_LSB +: TIME_W];
			out_zero_q <= zero_q;
			if (zero_q) begin
				out_vwap_q <= '0;
			end else if (sat_q) begin
				out_vwap_q <= '1;
			end else begin
				out_vwap_q <= quo_q;
			end
		end
	end

	// Status and outputs
	always_comb begin
		sts.emit     = full || (fill_inc == win_eff);
		sts.div_last = (cnt_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign window    = window_q;
	assign out_valid = out_valid_q;
	assign out_data  = {{OUT_PAD_W{1'b0}}, out_vwap_q, out_time_q};
	assign out_flag  = out_zero_q;

	// Checks
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_eff)
		else $error("fill count beyond window");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(slot_q) < win_eff)
		else $error("write slot beyond window");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output stage overwritten");

	a_zero_clears_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_zero_q) |-> (out_vwap_q == '0))
		else $error("nonzero value with zero volume");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && den_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

endmodule

`default_nettype wire
